// ===== hdl/lprd_pkg.sv =====
`default_nettype none
package lprd_pkg;

	localparam int unsigned LenBytes = 4;
	localparam logic [7:0] SEP_CHAR = 8'h3D;
	localparam logic [7:0] KEY_CHAR_O = 8'h6F;
	localparam logic [7:0] KEY_CHAR_P = 8'h70;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	localparam logic CFG_IDX_EXPECT_EN = 1'b0;
	localparam logic CFG_IDX_EXPECTED_OP = 1'b1;

	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_HDRLEN = 4'd1,
		PH_FIELDLEN = 4'd2,
		PH_KEY = 4'd3,
		PH_VALUE = 4'd4,
		PH_BODYLEN = 4'd5,
		PH_BODY = 4'd6,
		PH_DONE = 4'd7,
		PH_ERROR = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		CLS_NONE = 3'd0,
		CLS_HDRLEN = 3'd1,
		CLS_FIELDLEN = 3'd2,
		CLS_KEY = 3'd3,
		CLS_SEP = 3'd4,
		CLS_VALUE = 3'd5,
		CLS_BODYLEN = 3'd6,
		CLS_BODY = 3'd7
	} byte_class_t;

	typedef enum logic [3:0] {
		ERR_NONE = 4'd0,
		ERR_TRUNC_HDRLEN = 4'd1,
		ERR_HDR_OVER_INPUT = 4'd2,
		ERR_TRUNC_FIELDLEN = 4'd3,
		ERR_FIELD_OVER_HDR = 4'd4,
		ERR_MALFORMED = 4'd5,
		ERR_BAD_OP = 4'd6,
		ERR_WRONG_OP = 4'd7,
		ERR_TRUNC_BODYLEN = 4'd8,
		ERR_BODY_OVER_INPUT = 4'd9
	} err_t;

	localparam logic [1:0] KM_NONE = 2'd0;
	localparam logic [1:0] KM_START = 2'd1;
	localparam logic [1:0] KM_O = 2'd2;
	localparam logic [1:0] KM_OP = 2'd3;

	typedef struct packed {
		logic expect_op_enable;
		logic [7:0] expected_op;
	} cfg_t;

	typedef struct packed {
		logic cmd;
		logic [7:0] data_byte;
		logic [31:0] avail_len;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] byte_class;
		logic field_done;
		logic record_done;
		logic [3:0] fault_code;
		logic [7:0] op_value;
	} result_t;

endpackage
`default_nettype wire

// ===== hdl/length_prefixed_record_deframer_unit.sv =====
// length-prefixed record deframer
// item channel (item_valid / item_stall): cmd start with avail_len opens a
//   record, cmd data carries one record byte in data_byte
// result channel (result_valid / result_stall): one result per item with the
//   echoed byte, its class, field and record done flags, sticky error code
//   and the held op value
// config channel (cfg_valid / cfg_ready): index 0 expect_op_enable, index 1
//   expected_op; always ready, write only while no item is in flight
// pipeline: input register, then parse logic into the result register
// throughput: 1 item per cycle while the result is not stalled; each byte
//   only steps counters and the phase register
// stall: a stalled result holds; the input register keeps taking items until
//   it is full, then item_stall rises
// reset: parser returns to idle (bytes echo with class none until a start),
//   config registers clear, both pipeline stages empty
`default_nettype none
module length_prefixed_record_deframer_unit
	import lprd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_stall,
	input wire logic cmd,
	input wire logic [7:0] data_byte,
	input wire logic [31:0] avail_len,
	output logic result_valid,
	input wire logic result_stall,
	output logic [7:0] out_byte,
	output logic [2:0] byte_class,
	output logic field_done,
	output logic record_done,
	output logic [3:0] fault_code,
	output logic [7:0] op_value,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [7:0] cfg_data
);

	cfg_t cfg_q;
	logic valid_s1;
	item_t item_s1;
	logic res_valid_q;
	result_t res_q;
	result_t res_next;
	logic advance;

	assign advance = valid_s1 && (!res_valid_q || !result_stall);
	assign item_stall = valid_s1 && res_valid_q && result_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_IDX_EXPECT_EN: cfg_q.expect_op_enable <= cfg_data[0];
				CFG_IDX_EXPECTED_OP: cfg_q.expected_op <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= '{cmd: cmd, data_byte: data_byte, avail_len: avail_len};
		end
	end

	lprd_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.item(item_s1),
		.cfg(cfg_q),
		.result(res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || !result_stall) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign result_valid = res_valid_q;
	assign out_byte = res_q.out_byte;
	assign byte_class = res_q.byte_class;
	assign field_done = res_q.field_done;
	assign record_done = res_q.record_done;
	assign fault_code = res_q.fault_code;
	assign op_value = res_q.op_value;

endmodule
`default_nettype wire

// ===== hdl/lprd_parser.sv =====
`default_nettype none
module lprd_parser
	import lprd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic advance,
	input wire item_t item,
	input wire cfg_t cfg,
	output result_t result
);

	phase_t phase_q, n_phase;
	logic [23:0] lshift_q, n_lshift;
	logic [1:0] lcnt_q, n_lcnt;
	logic [31:0] avail_q, n_avail;
	logic [31:0] hdr_q, n_hdr;
	logic [31:0] fld_q, n_fld;
	logic [1:0] km_q, n_km;
	logic [7:0] op_q, n_op;
	logic opok_q, n_opok;
	err_t err_q, n_err;

	logic [31:0] avail_dec, hdr_dec, fld_dec, len_full;
	logic is_sep;

	assign avail_dec = avail_q - 32'd1;
	assign hdr_dec = hdr_q - 32'd1;
	assign fld_dec = fld_q - 32'd1;
	assign len_full = {item.data_byte, lshift_q};
	assign is_sep = (item.data_byte == SEP_CHAR);

	// next parse state for each item: start, length bytes, header fields and body
	always_comb begin
		logic stop;
		logic [31:0] h_left;
		logic [31:0] a_left;
		stop = 1'b0;
		h_left = hdr_q;
		a_left = avail_q;
		n_phase = phase_q;
		n_lshift = lshift_q;
		n_lcnt = lcnt_q;
		n_avail = avail_q;
		n_hdr = hdr_q;
		n_fld = fld_q;
		n_km = km_q;
		n_op = op_q;
		n_opok = opok_q;
		n_err = err_q;
		if (item.cmd == CMD_START) begin
			n_lshift = '0;
			n_lcnt = '0;
			n_avail = item.avail_len;
			n_hdr = '0;
			n_fld = '0;
			n_km = KM_NONE;
			n_op = '0;
			n_opok = 1'b0;
			n_err = ERR_NONE;
			n_phase = PH_HDRLEN;
			if (item.avail_len < 32'(LenBytes)) begin
				n_err = ERR_TRUNC_HDRLEN;
				n_phase = PH_ERROR;
			end
		end else begin
			unique case (phase_q) inside
				PH_HDRLEN, PH_FIELDLEN, PH_BODYLEN: begin
					n_avail = avail_dec;
					a_left = avail_dec;
					n_lcnt = lcnt_q + 2'd1;
					if (lcnt_q == 2'd0) n_lshift[7:0] = item.data_byte;
					if (lcnt_q == 2'd1) n_lshift[15:8] = item.data_byte;
					if (lcnt_q == 2'd2) n_lshift[23:16] = item.data_byte;
					if (phase_q == PH_FIELDLEN) begin
						n_hdr = hdr_dec;
					end
					if (lcnt_q == 2'd3) begin
						if (phase_q == PH_HDRLEN) begin
							n_hdr = len_full;
							h_left = len_full;
							if (len_full > avail_dec) begin
								n_err = ERR_HDR_OVER_INPUT;
								n_phase = PH_ERROR;
								stop = 1'b1;
							end else begin
								stop = 1'b0;
							end
						end else if (phase_q == PH_FIELDLEN) begin
							n_fld = len_full;
							stop = 1'b1;
							if (len_full > hdr_dec) begin
								n_err = ERR_FIELD_OVER_HDR;
								n_phase = PH_ERROR;
							end else if (len_full == 32'd0) begin
								n_err = ERR_MALFORMED;
								n_phase = PH_ERROR;
							end else begin
								n_km = KM_START;
								n_phase = PH_KEY;
							end
						end else begin
							n_fld = len_full;
							stop = 1'b1;
							if (len_full > avail_dec) begin
								n_err = ERR_BODY_OVER_INPUT;
								n_phase = PH_ERROR;
							end else if (len_full == 32'd0) begin
								n_phase = PH_DONE;
							end else begin
								n_phase = PH_BODY;
							end
						end
					end else begin
						stop = 1'b1;
					end
				end
				PH_KEY, PH_VALUE: begin
					n_avail = avail_dec;
					a_left = avail_dec;
					n_hdr = hdr_dec;
					h_left = hdr_dec;
					n_fld = fld_dec;
					if (phase_q == PH_KEY) begin
						if (is_sep) begin
							if (km_q == KM_START) begin
								n_err = ERR_MALFORMED;
								n_phase = PH_ERROR;
								stop = 1'b1;
							end else begin
								if (km_q == KM_OP) begin
									n_opok = 1'b0;
									n_km = KM_START;
								end else begin
									n_km = KM_NONE;
								end
								n_phase = PH_VALUE;
							end
						end else begin
							if (km_q == KM_START && item.data_byte == KEY_CHAR_O) n_km = KM_O;
							else if (km_q == KM_O && item.data_byte == KEY_CHAR_P)
								n_km = KM_OP;
							else n_km = KM_NONE;
							if (fld_dec == 32'd0) begin
								n_err = ERR_MALFORMED;
								n_phase = PH_ERROR;
								stop = 1'b1;
							end
						end
					end else begin
						if (km_q == KM_START) begin
							n_op = item.data_byte;
							n_km = KM_O;
						end else if (km_q == KM_O) begin
							n_km = KM_OP;
						end
					end
					if (!stop && fld_dec == 32'd0) begin
						if (n_km != KM_NONE) n_opok = (n_km == KM_O);
						n_km = KM_NONE;
					end else begin
						stop = 1'b1;
					end
				end
				PH_BODY: begin
					n_avail = avail_dec;
					n_fld = fld_dec;
					if (fld_dec == 32'd0) n_phase = PH_DONE;
					stop = 1'b1;
				end
				default: begin
					stop = 1'b1;
				end
			endcase
			if (!stop) begin
				n_lshift = '0;
				n_lcnt = '0;
				if (h_left == 32'd0) begin
					if (cfg.expect_op_enable && !n_opok) begin
						n_err = ERR_BAD_OP;
						n_phase = PH_ERROR;
					end else if (cfg.expect_op_enable && n_op != cfg.expected_op) begin
						n_err = ERR_WRONG_OP;
						n_phase = PH_ERROR;
					end else if (a_left < 32'(LenBytes)) begin
						n_err = ERR_TRUNC_BODYLEN;
						n_phase = PH_ERROR;
					end else begin
						n_phase = PH_BODYLEN;
					end
				end else if (h_left < 32'(LenBytes)) begin
					n_err = ERR_TRUNC_FIELDLEN;
					n_phase = PH_ERROR;
				end else begin
					n_phase = PH_FIELDLEN;
				end
			end
		end
	end

	always_comb begin
		byte_class_t cls;
		logic fdone;
		cls = CLS_NONE;
		fdone = 1'b0;
		if (item.cmd == CMD_DATA) begin
			unique case (phase_q)
				PH_HDRLEN: cls = CLS_HDRLEN;
				PH_FIELDLEN: cls = CLS_FIELDLEN;
				PH_KEY: begin
					cls = is_sep ? CLS_SEP : CLS_KEY;
					fdone = is_sep && km_q != KM_START && fld_dec == 32'd0;
				end
				PH_VALUE: begin
					cls = CLS_VALUE;
					fdone = (fld_dec == 32'd0);
				end
				PH_BODYLEN: cls = CLS_BODYLEN;
				PH_BODY: cls = CLS_BODY;
				default: cls = CLS_NONE;
			endcase
		end
		result.out_byte = (item.cmd == CMD_DATA) ? item.data_byte : 8'd0;
		result.byte_class = cls;
		result.field_done = fdone;
		result.record_done = (item.cmd == CMD_DATA) && phase_q != PH_DONE
			&& n_phase == PH_DONE;
		result.fault_code = n_err;
		result.op_value = n_opok ? n_op : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			lshift_q <= '0;
			lcnt_q <= '0;
			avail_q <= '0;
			hdr_q <= '0;
			fld_q <= '0;
			km_q <= KM_NONE;
			op_q <= '0;
			opok_q <= 1'b0;
			err_q <= ERR_NONE;
		end else if (advance) begin
			phase_q <= n_phase;
			lshift_q <= n_lshift;
			lcnt_q <= n_lcnt;
			avail_q <= n_avail;
			hdr_q <= n_hdr;
			fld_q <= n_fld;
			km_q <= n_km;
			op_q <= n_op;
			opok_q <= n_opok;
			err_q <= n_err;
		end
	end

endmodule
`default_nettype wire
